@@ src/mpps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll scheduler package
// Shared types and constants of the multi-slot periodic poll scheduler.
// ----------------------------------------------------------------------------
package mpps_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned PERIOD_W = 31;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned PROBE_W  = 4;
   localparam int unsigned SLOTF_W  = 4;
   localparam int unsigned CFG16_W  = 16;
   localparam int unsigned ACTIVE_W = 5;
   localparam int unsigned PADDR_W  = 5;
   localparam int unsigned PDATA_W  = 32;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HUMID = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEMP  = 2'd2;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   localparam logic [2:0] REG_ACTIVE_COUNT = 3'd0;
   localparam logic [2:0] REG_DEFAULT_PER  = 3'd1;
   localparam logic [2:0] REG_HUMID_MIN    = 3'd2;
   localparam logic [2:0] REG_TEMP_MIN     = 3'd3;
   localparam logic [2:0] REG_WAKE_HORIZON = 3'd4;

   localparam logic [ACTIVE_W-1:0] RST_ACTIVE_COUNT = 5'd0;
   localparam logic [CFG16_W-1:0]  RST_DEFAULT_PER  = 16'd5000;
   localparam logic [CFG16_W-1:0]  RST_HUMID_MIN    = 16'd2000;
   localparam logic [CFG16_W-1:0]  RST_TEMP_MIN     = 16'd1000;
   localparam logic [CFG16_W-1:0]  RST_WAKE_HORIZON = 16'd1000;

   typedef struct packed {
      logic [ACTIVE_W-1:0] active_count;
      logic [CFG16_W-1:0]  default_period_ms;
      logic [CFG16_W-1:0]  humidity_min_period_ms;
      logic [CFG16_W-1:0]  temp_min_period_ms;
      logic [CFG16_W-1:0]  wake_horizon_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]   due_time;
      logic [PERIOD_W-1:0] period;
      logic [KIND_W-1:0]   kind;
      logic [PROBE_W-1:0]  probe;
   } entry_type;

endpackage

@@ src/mpps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll scheduler channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpps_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [mpps_pkg::SLOTF_W-1:0]  slot;
   logic [mpps_pkg::KIND_W-1:0]   sensor_kind;
   logic [mpps_pkg::PERIOD_W-1:0] period_request_ms;
   logic [mpps_pkg::PROBE_W-1:0]  probe_index;
   logic [mpps_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, func, slot, sensor_kind, period_request_ms, probe_index,
                   now_ms, input ready);
   modport sink (input valid, func, slot, sensor_kind, period_request_ms, probe_index,
                 now_ms, output ready);
endinterface

interface mpps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mpps_pkg::SLOTF_W-1:0] due_slot;
   logic [mpps_pkg::KIND_W-1:0]  due_kind;
   logic [mpps_pkg::PROBE_W-1:0] due_probe;
   logic [mpps_pkg::TIME_W-1:0]  wake_time_ms;
   logic                         is_summary;
   logic                         last;

   modport source (output valid, due_slot, due_kind, due_probe, wake_time_ms, is_summary,
                   last, input ready);
   modport sink (input valid, due_slot, due_kind, due_probe, wake_time_ms, is_summary,
                 last, output ready);
endinterface

@@ src/mpps_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpps_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/mpps_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared time adder
// Modulo 2^32 adder and subtractor shared by the steps of the slot walk.
// ----------------------------------------------------------------------------
module mpps_alu (
   input  logic                            op,
   input  logic [mpps_pkg::TIME_W-1:0]     a,
   input  logic [mpps_pkg::TIME_W-1:0]     b,
   output logic [mpps_pkg::TIME_W-1:0]     y
);

   always_comb begin
      unique case (op)
         mpps_pkg::ALU_ADD: y = a + b;
         mpps_pkg::ALU_SUB: y = a - b;
         default:           y = a + b;
      endcase
   end

endmodule

@@ src/mpps_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll scheduler registers
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module mpps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mpps_pkg::PADDR_W-1:0]    paddr,
   input  logic [mpps_pkg::PDATA_W-1:0]    pwdata,
   output logic [mpps_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready,
   output mpps_pkg::cfg_type               cfg
);

   mpps_pkg::cfg_type cfg_ff;
   mpps_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index  = paddr[4:2];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            mpps_pkg::REG_ACTIVE_COUNT:
               cfg_in.active_count = pwdata[mpps_pkg::ACTIVE_W-1:0];
            mpps_pkg::REG_DEFAULT_PER:
               cfg_in.default_period_ms = pwdata[mpps_pkg::CFG16_W-1:0];
            mpps_pkg::REG_HUMID_MIN:
               cfg_in.humidity_min_period_ms = pwdata[mpps_pkg::CFG16_W-1:0];
            mpps_pkg::REG_TEMP_MIN:
               cfg_in.temp_min_period_ms = pwdata[mpps_pkg::CFG16_W-1:0];
            mpps_pkg::REG_WAKE_HORIZON:
               cfg_in.wake_horizon_ms = pwdata[mpps_pkg::CFG16_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_count           <= mpps_pkg::RST_ACTIVE_COUNT;
         cfg_ff.default_period_ms      <= mpps_pkg::RST_DEFAULT_PER;
         cfg_ff.humidity_min_period_ms <= mpps_pkg::RST_HUMID_MIN;
         cfg_ff.temp_min_period_ms     <= mpps_pkg::RST_TEMP_MIN;
         cfg_ff.wake_horizon_ms        <= mpps_pkg::RST_WAKE_HORIZON;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         mpps_pkg::REG_ACTIVE_COUNT: prdata = 32'(cfg_ff.active_count);
         mpps_pkg::REG_DEFAULT_PER:  prdata = 32'(cfg_ff.default_period_ms);
         mpps_pkg::REG_HUMID_MIN:    prdata = 32'(cfg_ff.humidity_min_period_ms);
         mpps_pkg::REG_TEMP_MIN:     prdata = 32'(cfg_ff.temp_min_period_ms);
         mpps_pkg::REG_WAKE_HORIZON: prdata = 32'(cfg_ff.wake_horizon_ms);
         default:                    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ src/multi_slot_periodic_poll_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-slot periodic poll scheduler
// Keeps a table of polling slots and walks it on every time tick.
// ----------------------------------------------------------------------------
// A request word either loads one slot (kind, probe, clamped period, due now)
// or carries the current millisecond time as a tick. A load gives no response.
// A tick walks the first active_count slots, at most SLOTS, one at a time
// through a single shared 32-bit adder and the slot RAM: each slot is read,
// checked, rewritten with its next due time if due, and compared with the
// wake time. Every due slot of known kind gives one read-request word, and
// the walk ends with one summary word holding the earliest wake time,
// flagged last. The request channel is not ready during a walk. Response
// words sit in an output register; when the receiver stalls, the walk waits
// at the next word to be sent. Reset clears the state, the slot index, the
// slot valid bits and the response valid flag; no clearing pass is needed,
// and a slot that was never loaded reads as unassigned.
// ----------------------------------------------------------------------------
module multi_slot_periodic_poll_scheduler #(
   parameter int unsigned SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   mpps_req_if.sink                     req_if,
   mpps_rsp_if.source                   rsp_if,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mpps_pkg::PADDR_W-1:0] paddr,
   input  logic [mpps_pkg::PDATA_W-1:0] pwdata,
   output logic [mpps_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);

   localparam int unsigned IDX_W   = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int unsigned ENTRY_W = $bits(mpps_pkg::entry_type);
   localparam int unsigned T_W     = mpps_pkg::TIME_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WAKE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;

   mpps_pkg::cfg_type cfg;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_idx_ff, last_idx_in;
   logic             none_ff, none_in;
   logic [T_W-1:0]   now_ff, now_in;
   logic [T_W-1:0]   wake_ff, wake_in;
   logic [T_W-1:0]   cur_due_ff, cur_due_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic             rd_valid_ff, rd_valid_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mpps_pkg::SLOTF_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [mpps_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [mpps_pkg::PROBE_W-1:0] rsp_probe_ff, rsp_probe_in;
   logic [T_W-1:0]               rsp_wake_ff, rsp_wake_in;
   logic                         rsp_sum_ff, rsp_sum_in;

   logic                alu_op;
   logic [T_W-1:0]      alu_a, alu_b, alu_y;
   logic                ram_we, ram_re;
   logic [IDX_W-1:0]    ram_waddr, ram_raddr;
   mpps_pkg::entry_type ram_wdata, ram_rdata, entry;
   logic                accept, out_free, load_hit, known;
   logic [mpps_pkg::PERIOD_W-1:0] clamped;
   logic [mpps_pkg::ACTIVE_W-1:0] n_eff;

   mpps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mpps_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   mpps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign load_hit     = accept && (req_if.func == mpps_pkg::FUNC_LOAD) &&
                         (32'(req_if.slot) < SLOTS);

   always_comb begin
      entry = ram_rdata;
      if (!rd_valid_ff) begin
         entry.kind  = mpps_pkg::KIND_NONE;
         entry.probe = '0;
      end
   end

   assign known = (entry.kind == mpps_pkg::KIND_HUMID) ||
                  (entry.kind == mpps_pkg::KIND_TEMP);

   always_comb begin
      priority if (req_if.period_request_ms == '0) begin
         clamped = 31'(cfg.default_period_ms);
      end else if ((req_if.sensor_kind == mpps_pkg::KIND_HUMID) &&
                   (req_if.period_request_ms < 31'(cfg.humidity_min_period_ms))) begin
         clamped = 31'(cfg.humidity_min_period_ms);
      end else if ((req_if.sensor_kind == mpps_pkg::KIND_TEMP) &&
                   (req_if.period_request_ms < 31'(cfg.temp_min_period_ms))) begin
         clamped = 31'(cfg.temp_min_period_ms);
      end else begin
         clamped = req_if.period_request_ms;
      end
   end

   assign n_eff = (32'(cfg.active_count) > SLOTS) ? mpps_pkg::ACTIVE_W'(SLOTS)
                                                  : cfg.active_count;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      none_in      = none_ff;
      now_in       = now_ff;
      wake_in      = wake_ff;
      cur_due_in   = cur_due_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_probe_in = rsp_probe_ff;
      rsp_wake_in  = rsp_wake_ff;
      rsp_sum_in   = rsp_sum_ff;
      alu_op       = mpps_pkg::ALU_ADD;
      alu_a        = now_ff;
      alu_b        = 32'(cfg.wake_horizon_ms);
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = entry;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff;
      rd_valid_in  = rd_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (load_hit) begin
               ram_we          = 1'b1;
               ram_waddr       = IDX_W'(req_if.slot);
               ram_wdata.due_time = req_if.now_ms;
               ram_wdata.period   = clamped;
               ram_wdata.kind     = req_if.sensor_kind;
               ram_wdata.probe    = req_if.probe_index;
               valid_in[IDX_W'(req_if.slot)] = 1'b1;
            end
            if (accept && (req_if.func == mpps_pkg::FUNC_TICK)) begin
               now_in      = req_if.now_ms;
               idx_in      = '0;
               none_in     = (n_eff == '0);
               last_idx_in = IDX_W'(n_eff - 5'd1);
               state_in    = S_WAKE;
            end
         end
         S_WAKE: begin
            wake_in     = alu_y;
            ram_re      = 1'b1;
            ram_raddr   = '0;
            rd_valid_in = valid_ff[0];
            state_in    = none_ff ? S_SUM : S_CHECK;
         end
         S_CHECK: begin
            alu_op     = mpps_pkg::ALU_SUB;
            alu_a      = now_ff;
            alu_b      = entry.due_time;
            cur_due_in = entry.due_time;
            state_in   = alu_y[T_W-1] ? S_CMP : S_UPD;
         end
         S_UPD: begin
            alu_op    = mpps_pkg::ALU_ADD;
            alu_a     = now_ff;
            alu_b     = 32'(entry.period);
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata.due_time = alu_y;
            cur_due_in = alu_y;
            if (!known || out_free) begin
               state_in = S_CMP;
            end
            if (known && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = mpps_pkg::SLOTF_W'(idx_ff);
               rsp_kind_in  = entry.kind;
               rsp_probe_in = entry.probe;
               rsp_wake_in  = '0;
               rsp_sum_in   = 1'b0;
            end
         end
         S_CMP: begin
            alu_op = mpps_pkg::ALU_SUB;
            alu_a  = cur_due_ff;
            alu_b  = wake_ff;
            if (alu_y[T_W-1]) begin
               wake_in = cur_due_ff;
            end
            if (idx_ff == last_idx_ff) begin
               state_in = S_SUM;
            end else begin
               idx_in      = idx_ff + 1'b1;
               ram_re      = 1'b1;
               ram_raddr   = idx_ff + 1'b1;
               rd_valid_in = valid_ff[idx_ff + 1'b1];
               state_in    = S_CHECK;
            end
         end
         S_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_kind_in  = mpps_pkg::KIND_NONE;
               rsp_probe_in = '0;
               rsp_wake_in  = wake_ff;
               rsp_sum_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff  <= last_idx_in;
      none_ff      <= none_in;
      now_ff       <= now_in;
      wake_ff      <= wake_in;
      cur_due_ff   <= cur_due_in;
      rd_valid_ff  <= rd_valid_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_probe_ff <= rsp_probe_in;
      rsp_wake_ff  <= rsp_wake_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.due_slot     = rsp_slot_ff;
   assign rsp_if.due_kind     = rsp_kind_ff;
   assign rsp_if.due_probe    = rsp_probe_ff;
   assign rsp_if.wake_time_ms = rsp_wake_ff;
   assign rsp_if.is_summary   = rsp_sum_ff;
   assign rsp_if.last         = rsp_sum_ff;

endmodule
